>>> sv/pvg_pkg.sv
// Shared constants, types and CORDIC angle table for the polygon vertex generator.
package pvg_pkg;
   localparam int MaxSidesDef     = 63;
   localparam int CordicStepsDef  = 16;
   localparam int FractionBitsDef = 8;
   localparam int AngleTableLen   = 24;
   localparam int GainQ16         = 39797;
   localparam int RadiusLimitMm   = 50;
   localparam int MinSides        = 3;

   // One queued job: clamped request fields.
   typedef struct packed {
      logic [7:0]         sides;
      logic [15:0]        radius;
      logic signed [14:0] centre_x;
      logic signed [14:0] centre_y;
   } job_type;

   // atan(2^-k) in units of 2^-32 turn
   function automatic logic [31:0] atan_turns(input logic [4:0] k);
      logic [31:0] v;
      case (k)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction
endpackage

>>> sv/polygon_vertex_generator_top.sv
// Top level of the polygon vertex generator: request queue plus CORDIC engine.
//
//  channel | direction | payload (low bit first)
//  req_    | in        | tdata: sides[5:0], radius[21:6], centre_x[36:22], centre_y[51:37]
//  rsp_    | out       | tdata: point_x[15:0], point_y[31:16]; tlast: last_point
//
// Each point passes through the divider, one setup step, CORDIC_STEPS rotation
// steps and the output states; the closing point skips the divide. A request
// of n sides gives n+1 points, after the job is picked up in the idle state.
// The shared divider and single CORDIC unit serve one point at a time.
// Reset is synchronous and clears the queue and engine state.
// A stalled rsp_ holds the engine; the two-entry request queue keeps taking
// requests meanwhile until it is full.
module polygon_vertex_generator_top #(
   parameter int MAX_SIDES     = pvg_pkg::MaxSidesDef,
   parameter int CORDIC_STEPS  = pvg_pkg::CordicStepsDef,
   parameter int FRACTION_BITS = pvg_pkg::FractionBitsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // sides, radius, centre_x, centre_y, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // point_x, point_y
   output logic        rsp_tlast    // last_point
);
   import pvg_pkg::*;
   job_type job;
   logic    job_valid, job_ready;

   // queue requests so the engine and the request side stall independently
   pvg_front #(.MAX_SIDES(MAX_SIDES), .FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_sides(req_tdata[5:0]), .in_radius(req_tdata[21:6]),
      .in_cx(req_tdata[36:22]), .in_cy(req_tdata[51:37]),
      .job_valid, .job_ready, .job
   );

   pvg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock, .reset, .job_valid, .job_ready, .job,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_x(rsp_tdata[15:0]), .out_y(rsp_tdata[31:16]), .out_last(rsp_tlast)
   );
endmodule

>>> sv/pvg_front.sv
// Request intake: clamps side count and radius and queues the job.
module pvg_front #(
   parameter int MAX_SIDES     = pvg_pkg::MaxSidesDef,
   parameter int FRACTION_BITS = pvg_pkg::FractionBitsDef
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [5:0]       in_sides,
   input  logic [15:0]      in_radius,
   input  logic [14:0]      in_cx,
   input  logic [14:0]      in_cy,
   output logic             job_valid,
   input  logic             job_ready,
   output pvg_pkg::job_type job
);
   import pvg_pkg::*;
   localparam logic [15:0] RadLim = 16'(RadiusLimitMm << FRACTION_BITS);
   localparam logic [7:0]  MaxS   = 8'(MAX_SIDES);

   job_type q_ff [2];
   logic    wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   job_type  cl;
   logic     push, pop;

   always_comb begin
      cl.sides = {2'b00, in_sides};
      if (cl.sides < 8'(MinSides)) cl.sides = 8'(MinSides);
      if (cl.sides > MaxS) cl.sides = MaxS;
      cl.radius   = (in_radius > RadLim) ? RadLim : in_radius;
      cl.centre_x = in_cx;
      cl.centre_y = in_cy;
   end

   assign in_ready  = (cnt_ff != 2'd2);
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = job_valid && job_ready;
   assign wp_in     = push ? ~wp_ff : wp_ff;
   assign rp_in     = pop ? ~rp_ff : rp_ff;
   assign cnt_in    = 2'(cnt_ff + {1'b0, push} - {1'b0, pop});

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= cl;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      push && !pop && cnt_ff == 2'd0 |=> cnt_ff == 2'd1) else $error("count slip");
`endif
endmodule

>>> sv/pvg_back.sv
// Job engine: phase stepping, iterative CORDIC and output register.
module pvg_back #(
   parameter int CORDIC_STEPS = pvg_pkg::CordicStepsDef
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  pvg_pkg::job_type job,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [15:0]      out_x,
   output logic [15:0]      out_y,
   output logic             out_last
);
   import pvg_pkg::*;
   localparam int StepW = $clog2(CORDIC_STEPS + 1);
   localparam int XW    = 36;   // radius*gain plus CORDIC growth
   localparam int ZW    = 34;

   localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_ROT = 3'd2,
                          S_FIN = 3'd3, S_OUT = 3'd4, S_MUL = 3'd5;

   logic [2:0]  st_ff, st_in;
   job_type     job_ff;
   logic [7:0]  idx_ff;
   logic [7:0]  rem_ff;             // partial remainder of the divider
   logic [15:0] quo_ff;
   logic [4:0]  dcnt_ff;
   logic [StepW-1:0] k_ff;
   logic signed [XW-1:0] x_ff, y_ff;
   logic signed [ZW-1:0] z_ff;
   logic        flip_ff;
   logic [15:0] ox_ff, oy_ff;
   logic        olast_ff, ovalid_ff, ovalid_in;

   logic [15:0] ph, pf;
   logic        fl;
   logic [8:0]  trial;
   logic signed [XW-1:0] xs, ys, xr, yr;
   logic signed [16:0] cr, sr;

   assign job_ready = (st_ff == S_IDLE);
   assign out_valid = ovalid_ff;
   assign out_x     = ox_ff;
   assign out_y     = oy_ff;
   assign out_last  = olast_ff;

   // load a new beat when the engine finishes, else drop the taken one
   assign ovalid_in = (st_ff == S_FIN && (!ovalid_ff || out_ready)) ? 1'b1 :
                      (out_ready ? 1'b0 : ovalid_ff);

   // restoring divide step: 8-bit partial remainder with one new dividend bit
   assign trial = {rem_ff, quo_ff[15]} - {1'b0, job_ff.sides};

   always_comb begin
      ph = 16'(quo_ff + 16'd16384);
      fl = (ph >= 16'd16384) && (ph < 16'd49152);
      pf = fl ? 16'(ph - 16'd32768) : ph;
   end

   assign xs = x_ff >>> k_ff;
   assign ys = y_ff >>> k_ff;
   assign xr = (x_ff + $signed(XW'(32768))) >>> 16;
   assign yr = (y_ff + $signed(XW'(32768))) >>> 16;
   assign cr = flip_ff ? -17'(xr) : 17'(xr);
   assign sr = flip_ff ? -17'(yr) : 17'(yr);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE: if (job_valid) st_in = S_DIV;
         S_DIV:  if (dcnt_ff == 5'd16 || idx_ff == job_ff.sides) st_in = S_MUL;
         S_MUL:  st_in = S_ROT;
         S_ROT:  if (k_ff == StepW'(CORDIC_STEPS - 1)) st_in = S_FIN;
         S_FIN:  if (!ovalid_ff || out_ready) st_in = S_OUT;
         S_OUT:  st_in = (idx_ff == job_ff.sides) ? S_IDLE : S_DIV;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         ovalid_ff <= ovalid_in;
      end
      case (st_ff)
         S_IDLE: begin
            job_ff  <= job;
            idx_ff  <= 8'd0;
            quo_ff  <= 16'd0;
            rem_ff  <= 8'd0;
            dcnt_ff <= 5'd0;
         end
         S_DIV: begin
            // divide idx*65536 by sides, one quotient bit a cycle; quo_ff
            // holds dividend bits shifting out the top, quotient bits in
            if (idx_ff == job_ff.sides) begin
               quo_ff <= 16'd0;           // closing point repeats phase 0
            end else if (dcnt_ff != 5'd16) begin
               dcnt_ff <= 5'(dcnt_ff + 5'd1);
               if (!trial[8]) begin
                  rem_ff <= trial[7:0];
                  quo_ff <= {quo_ff[14:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[6:0], quo_ff[15]};
                  quo_ff <= {quo_ff[14:0], 1'b0};
               end
            end
         end
         S_MUL: begin
            flip_ff <= fl;
            z_ff    <= ZW'($signed(pf)) <<< 16;
            x_ff    <= XW'(job_ff.radius) * XW'(GainQ16);
            y_ff    <= '0;
            k_ff    <= '0;
         end
         S_ROT: begin
            k_ff <= StepW'(k_ff + 1'b1);
            if (!z_ff[ZW-1]) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - ZW'(atan_turns(5'(k_ff)));
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + ZW'(atan_turns(5'(k_ff)));
            end
         end
         S_FIN: if (!ovalid_ff || out_ready) begin
            ox_ff    <= 16'(cr + 17'(job_ff.centre_x));
            oy_ff    <= 16'(sr + 17'(job_ff.centre_y));
            olast_ff <= (idx_ff == job_ff.sides);
         end
         S_OUT: begin
            idx_ff  <= 8'(idx_ff + 8'd1);
            dcnt_ff <= 5'd0;
            // dividend (idx+1)*65536: seed the partial remainder with idx+1,
            // below sides except on the closing point
            rem_ff  <= 8'(idx_ff + 8'd1);
            quo_ff  <= 16'd0;
         end
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid) else $error("result dropped");
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_OUT && idx_ff == job_ff.sides |=> st_ff == S_IDLE)
      else $error("run did not end");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != S_IDLE |-> !job_ready) else $error("accept while busy");
`endif
endmodule
